// ===== hdl/fpa_pkg.sv =====
// fpa_pkg: shared types, codes and defaults of the fit-policy partition allocator
// no dependencies; every other file imports this package
`default_nettype none

package fpa_pkg;

  localparam int DEFAULT_NUM_BLOCKS = 16;
  localparam int DEFAULT_SIZE_BITS  = 16;

  localparam int IDX_IN_W  = 4;
  localparam int AMOUNT_W  = 16;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 5;
  localparam int POLICY_W  = 2;

  typedef enum logic [0:0] {
    MODE_LOAD    = 1'b0,
    MODE_REQUEST = 1'b1
  } fpa_mode_e;

  typedef enum logic [POLICY_W-1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2,
    POL_NEXT  = 2'd3
  } fpa_policy_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED  = 2'd0,
    ST_GRANTED = 2'd1,
    ST_DENIED  = 2'd2
  } fpa_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLICY = 1'b0,
    CFG_ACTIVE = 1'b1
  } fpa_cfg_idx_e;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic start;
    logic issue;
    logic fin_load;
    logic fin_req;
  } fpa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
    logic hit_stop;
    logic scan_done;
  } fpa_stat_t;

endpackage

`default_nettype wire

// ===== hdl/fpa_if.sv =====
// fpa_if: valid/ready channel interfaces for request, result and configuration
// depends on fpa_pkg for field widths
`default_nettype none

interface fpa_in_if import fpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                mode;
  logic [IDX_IN_W-1:0] block_index;
  logic [AMOUNT_W-1:0] amount;
  modport source (output valid, mode, block_index, amount, input ready);
  modport sink   (input valid, mode, block_index, amount, output ready);
endinterface

interface fpa_out_if import fpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_IN_W-1:0] granted_block;
  logic [AMOUNT_W-1:0] remaining;
  modport source (output valid, status, granted_block, remaining, input ready);
  modport sink   (input valid, status, granted_block, remaining, output ready);
endinterface

interface fpa_cfg_if import fpa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/fit_policy_partition_allocator.sv =====
// fit_policy_partition_allocator: top level, first/best/worst/next fit allocator
// depends on fpa_pkg, fpa_if, fpa_ctrl, fpa_datapath
//
//   channel  dir  payload                              transfer when
//   in_if    in   mode, block_index, amount            valid && ready
//   out_if   out  status, granted_block, remaining     valid && ready
//   cfg_if   in   index (0 policy, 1 active), data     valid && ready
//
// load item: the result goes to the output register from the load state once the slot is free
// request: scans m partitions, m = searched partitions (one store read per cycle);
//   first and next fit end the scan once the first fitting partition is found
// reset: capacities read as zero via per-entry valid bits, policy first fit, 16 active
// a held result does not block the next input transfer; a new result waits for the slot
`default_nettype none

module fit_policy_partition_allocator import fpa_pkg::*; #(
  parameter int NUM_BLOCKS = DEFAULT_NUM_BLOCKS,
  parameter int SIZE_BITS  = DEFAULT_SIZE_BITS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fpa_in_if.sink     in_if,
  fpa_out_if.source  out_if,
  fpa_cfg_if.sink    cfg_if
);

  fpa_cmd_t  cmd;
  fpa_stat_t stat;

  assign cfg_if.ready = 1'b1;

  fpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_mode_i  (in_if.mode),
    .in_ready_o (in_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fpa_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .block_index_i   (in_if.block_index),
    .amount_i        (in_if.amount),
    .cfg_we_i        (cfg_if.valid),
    .cfg_index_i     (cfg_if.index),
    .cfg_data_i      (cfg_if.data),
    .out_valid_o     (out_if.valid),
    .out_ready_i     (out_if.ready),
    .status_o        (out_if.status),
    .granted_block_o (out_if.granted_block),
    .remaining_o     (out_if.remaining)
  );

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("input taken while an item is in work");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.fin_load || cmd.fin_req) |-> !(out_if.valid && !out_if.ready))
    else $error("result register overwritten while stalled");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_if.valid) |-> $past(cmd.fin_load || cmd.fin_req))
    else $error("result appeared without a finishing command");
`endif

endmodule

`default_nettype wire

// ===== hdl/fpa_datapath.sv =====
// fpa_datapath: capacity store, config registers, pipelined scan, output register
// depends on fpa_pkg; driven by fpa_ctrl through fpa_cmd_t
`default_nettype none

module fpa_datapath import fpa_pkg::*; #(
  parameter int NUM_BLOCKS = DEFAULT_NUM_BLOCKS,
  parameter int SIZE_BITS  = DEFAULT_SIZE_BITS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire fpa_cmd_t             cmd_i,
  output fpa_stat_t                 stat_o,
  input  wire logic [IDX_IN_W-1:0]  block_index_i,
  input  wire logic [AMOUNT_W-1:0]  amount_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [STATUS_W-1:0]       status_o,
  output logic [IDX_IN_W-1:0]       granted_block_o,
  output logic [AMOUNT_W-1:0]       remaining_o
);

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  // config
  fpa_policy_e          policy_q;
  logic [CFG_DAT_W-1:0] active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_FIRST;
      active_q <= CFG_DAT_W'(16);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_POLICY: policy_q <= fpa_policy_e'(cfg_data_i[POLICY_W-1:0]);
        CFG_ACTIVE: active_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // searched count and next-fit start
  logic [CNT_W-1:0] m_cnt;
  logic [IDX_W-1:0] ptr_q;
  logic [IDX_W-1:0] pos_start;

  assign m_cnt     = (32'(active_q) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS) : CNT_W'(active_q);
  assign pos_start = (CNT_W'(ptr_q) < m_cnt) ? ptr_q : '0;

  // latched item
  logic [IDX_IN_W-1:0]  idx_q;
  logic [SIZE_BITS-1:0] need_q;
  logic                 idx_ok;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      idx_q  <= block_index_i;
      need_q <= SIZE_BITS'(amount_i);
    end
  end

  assign idx_ok = (32'(idx_q) < NUM_BLOCKS);

  // scan control
  logic [IDX_W-1:0] pos_q;
  logic [CNT_W-1:0] issue_cnt_q;
  logic             issue_done;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_pos_q;
  logic             found_q;
  logic [IDX_W-1:0] pick_q;
  logic [SIZE_BITS-1:0] pick_cap_q;

  assign issue_done = (issue_cnt_q == m_cnt);

  // capacity store with per-entry valid bits
  logic [SIZE_BITS-1:0] cap_mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] vld_q;
  logic [SIZE_BITS-1:0] rd_data_q;
  logic                 rd_vbit_q;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [SIZE_BITS-1:0] wr_data;
  logic [SIZE_BITS-1:0] new_cap;

  assign new_cap = pick_cap_q - need_q;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pick_q;
    wr_data = new_cap;
    if (cmd_i.fin_load) begin
      wr_en   = idx_ok;
      wr_addr = IDX_W'(idx_q);
      wr_data = need_q;
    end else if (cmd_i.fin_req) begin
      wr_en = found_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cap_mem[wr_addr] <= wr_data;
    end
    rd_data_q <= cap_mem[pos_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vbit_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      rd_vbit_q <= vld_q[pos_q];
    end
  end

  // compare stage
  logic [SIZE_BITS-1:0] cap_eff;
  logic                 fits;
  logic                 upd;
  logic                 sel_first;

  assign cap_eff   = rd_vbit_q ? rd_data_q : '0;
  assign fits      = (cap_eff >= need_q);
  assign sel_first = (policy_q == POL_FIRST) || (policy_q == POL_NEXT);
  assign upd = rd_vld_q && fits &&
               (!found_q ||
                ((policy_q == POL_BEST)  && (cap_eff < pick_cap_q)) ||
                ((policy_q == POL_WORST) && (cap_eff > pick_cap_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      issue_cnt_q <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      ptr_q       <= '0;
    end else begin
      rd_vld_q <= cmd_i.issue && !issue_done;
      if (cmd_i.start) begin
        pos_q       <= (policy_q == POL_NEXT) ? pos_start : '0;
        issue_cnt_q <= '0;
        found_q     <= 1'b0;
        if ((policy_q == POL_NEXT) && (m_cnt != '0)) begin
          ptr_q <= pos_start;
        end
      end else begin
        if (cmd_i.issue && !issue_done) begin
          issue_cnt_q <= issue_cnt_q + 1'b1;
          pos_q <= ((CNT_W'(pos_q) + 1'b1) == m_cnt) ? '0 : pos_q + 1'b1;
        end
        if (upd) begin
          found_q <= 1'b1;
        end
        if (cmd_i.fin_req && found_q && (policy_q == POL_NEXT)) begin
          ptr_q <= pick_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_pos_q <= pos_q;
    if (upd) begin
      pick_q     <= rd_pos_q;
      pick_cap_q <= cap_eff;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.fin_load || cmd_i.fin_req) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_load) begin
      status_o        <= ST_LOADED;
      granted_block_o <= idx_q;
      remaining_o     <= idx_ok ? AMOUNT_W'(need_q) : '0;
    end else if (cmd_i.fin_req) begin
      if (found_q) begin
        status_o        <= ST_GRANTED;
        granted_block_o <= IDX_IN_W'(pick_q);
        remaining_o     <= AMOUNT_W'(new_cap);
      end else begin
        status_o        <= ST_DENIED;
        granted_block_o <= '0;
        remaining_o     <= '0;
      end
    end
  end

  assign stat_o.out_busy  = out_valid_o && !out_ready_i;
  assign stat_o.hit_stop  = found_q && sel_first;
  assign stat_o.scan_done = issue_done && !rd_vld_q;

endmodule

`default_nettype wire

// ===== hdl/fpa_ctrl.sv =====
// fpa_ctrl: sequencer for load and allocation items
// depends on fpa_pkg; commands fpa_datapath through fpa_cmd_t
`default_nettype none

module fpa_ctrl import fpa_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_mode_i,
  output logic           in_ready_o,
  input  wire fpa_stat_t stat_i,
  output fpa_cmd_t       cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_START = 5'b00100,
    S_SCAN  = 5'b01000,
    S_GRANT = 5'b10000
  } fpa_state_e;

  fpa_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d = (in_mode_i == MODE_REQUEST) ? S_START : S_LOAD;
        end
      end
      S_LOAD: begin
        if (!stat_i.out_busy) begin
          cmd_o.fin_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_START: begin
        cmd_o.start = 1'b1;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.issue = 1'b1;
        if (stat_i.hit_stop || stat_i.scan_done) begin
          state_d = S_GRANT;
        end
      end
      S_GRANT: begin
        if (!stat_i.out_busy) begin
          cmd_o.fin_req = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb_fit_policy_partition_allocator.sv =====
// tb_fit_policy_partition_allocator: self-checking bench for the fit-policy partition allocator
// depends on fpa_pkg, fpa_if and the allocator rtl; a ledger class predicts and checks results
`default_nettype none

module tb_fit_policy_partition_allocator;
  import fpa_pkg::*;

  localparam int NBLK         = DEFAULT_NUM_BLOCKS;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 24;
  localparam int PHASES       = 26;
  localparam int PHASE_ITEMS  = 50;

  typedef struct packed {
    fpa_status_e         status;
    logic [IDX_IN_W-1:0] granted_block;
    logic [AMOUNT_W-1:0] remaining;
  } alloc_result_t;

  class partition_ledger;
    logic [AMOUNT_W-1:0]  capacity [NBLK];
    logic [IDX_IN_W-1:0]  next_ptr;
    fpa_policy_e          policy;
    logic [CFG_DAT_W-1:0] active;
    alloc_result_t        awaited [$];
    int                   errors;

    function new();
      foreach (capacity[k]) capacity[k] = '0;
      next_ptr = '0;
      policy   = POL_FIRST;
      active   = CFG_DAT_W'(NBLK);
      errors   = 0;
    endfunction

    function void write_register(fpa_cfg_idx_e idx, logic [CFG_DAT_W-1:0] data);
      if (idx == CFG_POLICY) begin
        policy = fpa_policy_e'(data[POLICY_W-1:0]);
      end else begin
        active = data;
      end
    endfunction

    // partition picked for a request, -1 when none of the searched ones has room
    function int choose_partition(logic [AMOUNT_W-1:0] need);
      int m;
      int pos;
      int pick;
      int k;
      m    = (int'(active) > NBLK) ? NBLK : int'(active);
      pick = -1;
      if (m == 0) return -1;
      if (policy == POL_NEXT) begin
        pos = (int'(next_ptr) < m) ? int'(next_ptr) : 0;
        next_ptr = pos[IDX_IN_W-1:0];
        for (k = 0; k < m; k++) begin
          if (capacity[pos] >= need) begin
            next_ptr = pos[IDX_IN_W-1:0];
            return pos;
          end
          pos = (pos + 1 == m) ? 0 : pos + 1;
        end
        return -1;
      end
      for (k = 0; k < m; k++) begin
        if (capacity[k] >= need) begin
          if (policy == POL_FIRST) return k;
          if (pick < 0 ||
              (policy == POL_BEST && capacity[k] < capacity[pick]) ||
              (policy == POL_WORST && capacity[k] > capacity[pick]))
            pick = k;
        end
      end
      return pick;
    endfunction

    function void note_item(fpa_mode_e mode, logic [IDX_IN_W-1:0] idx,
                            logic [AMOUNT_W-1:0] amt);
      alloc_result_t r;
      int pick;
      if (mode == MODE_LOAD) begin
        capacity[idx] = amt;
        r = '{ST_LOADED, idx, amt};
      end else begin
        pick = choose_partition(amt);
        if (pick >= 0) begin
          capacity[pick] = capacity[pick] - amt;
          r = '{ST_GRANTED, pick[IDX_IN_W-1:0], capacity[pick]};
        end else begin
          r = '{ST_DENIED, '0, '0};
        end
      end
      awaited.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [IDX_IN_W-1:0] blk,
                               logic [AMOUNT_W-1:0] rem);
      alloc_result_t exp;
      if (awaited.size() == 0) begin
        errors++;
        $error("unexpected result: status %0d granted_block %0d remaining %0d", st, blk, rem);
        return;
      end
      exp = awaited.pop_front();
      if (st !== exp.status) begin
        errors++;
        $error("status: expected %0d, actual %0d", exp.status, st);
      end
      if (blk !== exp.granted_block) begin
        errors++;
        $error("granted_block: expected %0d, actual %0d", exp.granted_block, blk);
      end
      if (rem !== exp.remaining) begin
        errors++;
        $error("remaining: expected %0d, actual %0d", exp.remaining, rem);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  fpa_in_if  in_if ();
  fpa_out_if out_if ();
  fpa_cfg_if cfg_if ();

  fit_policy_partition_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  partition_ledger ledger;
  bit              tx_steady;
  bit              rx_steady;
  bit              rx_hold_req;
  int unsigned     cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_fit_policy_partition_allocator: errors");
      $finish;
    end
  end

  task automatic send_item(fpa_mode_e mode, logic [IDX_IN_W-1:0] idx,
                           logic [AMOUNT_W-1:0] amt);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid       = 1'b1;
    in_if.mode        = mode;
    in_if.block_index = idx;
    in_if.amount      = amt;
    do @(posedge clk_i); while (!in_if.ready);
    ledger.note_item(mode, idx, amt);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_if.valid = 1'b0;
    while (ledger.awaited.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_cfg(fpa_cfg_idx_e idx, logic [CFG_DAT_W-1:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk_i); while (!cfg_if.ready);
    ledger.write_register(idx, data);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // upper data bits of the policy write are junk on purpose
  task automatic configure(fpa_policy_e pol, logic [CFG_DAT_W-1:0] act);
    logic [CFG_DAT_W-1:0] data;
    settle();
    data = CFG_DAT_W'($urandom);
    data[POLICY_W-1:0] = pol;
    write_cfg(CFG_POLICY, data);
    write_cfg(CFG_ACTIVE, act);
  endtask

  task automatic send_random_item(logic [CFG_DAT_W-1:0] act);
    fpa_mode_e           mode;
    logic [IDX_IN_W-1:0] idx;
    logic [AMOUNT_W-1:0] amt;
    int                  lim;
    int                  sel;
    lim  = (int'(act) == 0 || int'(act) > NBLK) ? NBLK : int'(act);
    idx  = ($urandom_range(0, 3) == 0) ? IDX_IN_W'($urandom_range(0, 15))
                                       : IDX_IN_W'($urandom_range(0, lim - 1));
    mode = ($urandom_range(0, 99) < 35) ? MODE_LOAD : MODE_REQUEST;
    sel  = $urandom_range(0, 9);
    if (mode == MODE_LOAD) begin
      if (sel < 5)      amt = AMOUNT_W'($urandom);
      else if (sel < 8) amt = AMOUNT_W'($urandom_range(0, 255));
      else if (sel == 8) amt = '1;
      else              amt = '0;
    end else begin
      // exact fits exercise ties and drained partitions
      if (sel < 4)      amt = ledger.capacity[$urandom_range(0, lim - 1)];
      else if (sel < 7) amt = AMOUNT_W'($urandom_range(0, 4095));
      else if (sel == 7) amt = AMOUNT_W'($urandom);
      else if (sel == 8) amt = '0;
      else              amt = '1;
    end
    send_item(mode, idx, amt);
  endtask

  initial begin : result_sink
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = rx_steady ? 0 : $urandom_range(0, 19);
      end
      if (stall > 0) begin
        out_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready = 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      ledger.check_result(out_if.status, out_if.granted_block, out_if.remaining);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    fpa_policy_e          pol;
    logic [CFG_DAT_W-1:0] act;
    int                   sel;
    ledger            = new();
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.mode        = MODE_LOAD;
    in_if.block_index = '0;
    in_if.amount      = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = CFG_POLICY;
    cfg_if.data       = '0;
    tx_steady         = 1'b0;
    rx_steady         = 1'b0;
    rx_hold_req       = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty store under reset settings
    send_item(MODE_REQUEST, 4'hF, 16'd1);
    send_item(MODE_REQUEST, 4'h0, 16'd0);
    send_item(MODE_LOAD, 4'hF, 16'hFFFF);
    send_item(MODE_LOAD, 4'h0, 16'h0000);
    send_item(MODE_LOAD, 4'h5, 16'h8000);
    send_item(MODE_LOAD, 4'h9, 16'h5555);
    send_item(MODE_LOAD, 4'hA, 16'hAAAA);
    send_item(MODE_REQUEST, 4'h0, 16'hFFFF);
    send_item(MODE_REQUEST, 4'h0, 16'h4000);

    // best fit with a tie between two partitions
    configure(POL_BEST, 5'd16);
    send_item(MODE_LOAD, 4'h2, 16'h5555);
    send_item(MODE_REQUEST, 4'h0, 16'h5000);

    configure(POL_WORST, 5'd16);
    send_item(MODE_REQUEST, 4'h7, 16'd1);

    // next fit pointer stays on the granted partition
    configure(POL_NEXT, 5'd16);
    send_item(MODE_REQUEST, 4'h0, 16'h5000);
    send_item(MODE_REQUEST, 4'h0, 16'h0000);

    // pointer now beyond the active range
    configure(POL_NEXT, 5'd4);
    send_item(MODE_REQUEST, 4'h0, 16'hFFFF);

    // nothing searched; load outside the active range
    configure(POL_FIRST, 5'd0);
    send_item(MODE_REQUEST, 4'h0, 16'h0000);
    send_item(MODE_LOAD, 4'hC, 16'h0F0F);

    // active count above the table size
    configure(POL_FIRST, 5'd31);
    send_item(MODE_REQUEST, 4'h3, 16'h0F0F);

    configure(POL_WORST, 5'd1);
    send_item(MODE_REQUEST, 4'h0, 16'h0000);

    for (int ph = 0; ph < PHASES; ph++) begin
      pol = (ph < 4) ? fpa_policy_e'(ph) : fpa_policy_e'($urandom_range(0, 3));
      sel = $urandom_range(0, 19);
      case (ph)
        0:       act = 5'd16;
        1:       act = 5'd1;
        2:       act = 5'd31;
        3:       act = 5'd0;
        default: begin
          if (sel == 0)      act = 5'd0;
          else if (sel == 1) act = CFG_DAT_W'($urandom_range(17, 31));
          else               act = CFG_DAT_W'($urandom_range(1, 16));
        end
      endcase
      configure(pol, act);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      if (ph == 5) begin
        tx_steady   = 1'b1;
        rx_hold_req = 1'b1;
      end
      repeat (PHASE_ITEMS) send_random_item(act);
    end

    settle();
    if (ledger.errors == 0 && ledger.awaited.size() == 0) begin
      $display("tb_fit_policy_partition_allocator: clean");
    end else begin
      $display("tb_fit_policy_partition_allocator: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
